@@ hw/rtl/thms_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the step table of the timed HID macro sequencer.
package thms_pkg;

	localparam int TABLE_STEPS = 8;
	localparam int ENTRIES     = 8;
	localparam int POS_W       = $clog2(ENTRIES);
	localparam int LIMIT_W     = POS_W + 1;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS);
	localparam int DELAY_W     = 7;
	localparam int TIME_W      = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(TABLE_STEPS < ENTRIES ? TABLE_STEPS
		: ENTRIES);

	// configuration register indexes
	localparam logic [1:0] CFG_STEP_COUNT   = 2'd0;
	localparam logic [1:0] CFG_TRIGGER_CODE = 2'd1;
	localparam logic [1:0] CFG_VENDOR_ID    = 2'd2;

	localparam logic [3:0] STEP_COUNT_RST   = 4'd8;
	localparam logic [7:0] TRIGGER_CODE_RST = 8'h51;
	localparam logic [7:0] VENDOR_ID_RST    = 8'd3;

	// input action codes
	localparam logic ACT_TICK   = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	// report kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_KEY   = 2'd1;
	localparam logic [1:0] KIND_MOUSE = 2'd2;

	localparam logic [7:0] BTN_L     = 8'h01;
	localparam logic [7:0] BTN_R     = 8'h02;
	localparam logic [7:0] KEY_EIGHT = 8'h25;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         key;
		logic [7:0]         buttons;
		logic [DELAY_W-1:0] delay;
	} step_t;

	// one request handed from the front to the back
	typedef struct packed {
		logic              is_start;
		logic [TIME_W-1:0] now;
		logic              ready;
	} cmd_t;

	function automatic step_t step_lookup(input logic [POS_W-1:0] pos);
		step_t s;
		case (pos)
			3'd0:    s = '{kind: KIND_MOUSE, key: 8'h00,     buttons: BTN_R, delay: 7'd10};
			3'd1:    s = '{kind: KIND_MOUSE, key: 8'h00,     buttons: 8'h00, delay: 7'd90};
			3'd2:    s = '{kind: KIND_MOUSE, key: 8'h00,     buttons: BTN_L, delay: 7'd10};
			3'd3:    s = '{kind: KIND_MOUSE, key: 8'h00,     buttons: 8'h00, delay: 7'd5};
			3'd4:    s = '{kind: KIND_KEY,   key: KEY_EIGHT, buttons: 8'h00, delay: 7'd8};
			3'd5:    s = '{kind: KIND_KEY,   key: 8'h00,     buttons: 8'h00, delay: 7'd5};
			3'd6:    s = '{kind: KIND_MOUSE, key: 8'h00,     buttons: BTN_R, delay: 7'd10};
			default: s = '{kind: KIND_MOUSE, key: 8'h00,     buttons: 8'h00, delay: 7'd0};
		endcase
		return s;
	endfunction

	// clamp the configured count to one..table size
	function automatic logic [LIMIT_W-1:0] step_limit(input logic [3:0] count);
		logic [LIMIT_W-1:0] n;
		if (count == 4'd0)
			n = LIMIT_W'(1);
		else if ({1'b0, count} > 5'(LIMIT_MAX))
			n = LIMIT_MAX;
		else
			n = LIMIT_W'(count);
		return n;
	endfunction

endpackage

@@ hw/rtl/thms_front.sv @@
`timescale 1ns / 1ps
// Front end: classifies incoming items and queues ticks and trigger requests.
module thms_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              action,
	input  logic [31:0]       now_ms,
	input  logic [7:0]        rpt_id,
	input  logic [7:0]        first_byte,
	input  logic [6:0]        report_length,
	input  logic              host_ready,
	input  logic [7:0]        trigger_code,
	input  logic [7:0]        vendor_id,
	output logic              cmd_valid,
	output thms_pkg::cmd_t    cmd,
	input  logic              cmd_pop
);
	import thms_pkg::*;

	localparam int DEPTH = 2;

	cmd_t       queue_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       keep;
	logic       push;
	logic       pop;

	// drop reports that are not triggers; the back end decides on running state
	assign keep = (action == ACT_TICK) ||
		(rpt_id == vendor_id && report_length != 7'd0 &&
		 first_byte == trigger_code);

	assign item_stall = (fill_q == 2'(DEPTH));
	assign push       = item_valid && !item_stall && keep;
	assign pop        = cmd_pop && cmd_valid;
	assign cmd_valid  = (fill_q != 2'd0);
	assign cmd        = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{is_start: (action == ACT_REPORT), now: now_ms,
				ready: host_ready};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/thms_back.sv @@
`timescale 1ns / 1ps
// Back end: runs due steps one per cycle while the result slot is free and holds the result register.
module thms_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  thms_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	input  logic [3:0]        step_count,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [1:0]        report_kind,
	output logic [7:0]        key_code,
	output logic [7:0]        mouse_buttons,
	output logic              delivered,
	output logic              sequence_done,
	output logic              last
);
	import thms_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t             state_q;
	logic               running_q;
	logic [POS_W-1:0]   pos_q;
	logic [TIME_W-1:0]  due_q;
	logic [TIME_W-1:0]  now_q;
	logic               ready_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic [1:0]         kind_q;
	logic [7:0]         key_q;
	logic [7:0]         buttons_q;
	logic               delivered_q;
	logic               done_q;
	logic               last_q;

	step_t              cur;
	logic [LIMIT_W-1:0] next_pos;
	logic               step_done;
	logic               step_last;
	logic               is_due;
	logic               slot_free;
	logic               fire;

	assign cur       = step_lookup(pos_q);
	assign next_pos  = {1'b0, pos_q} + LIMIT_W'(1);
	assign step_done = (next_pos >= step_limit(step_count));
	// a zero delay keeps the step due at the same time, so only these end the chain
	assign step_last = step_done || (cur.delay != '0) || (cnt_q == CNT_W'(MAX_RESULTS - 1));
	assign is_due    = running_q && (now_q >= due_q);
	assign slot_free = !out_valid_q || !result_stall;
	assign fire      = (state_q == ST_EXEC) && is_due && slot_free;
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= 1'b0;
			pos_q       <= '0;
			due_q       <= '0;
			now_q       <= '0;
			ready_q     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_NONE;
			key_q       <= '0;
			buttons_q   <= '0;
			delivered_q <= 1'b0;
			done_q      <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (fire)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !result_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						now_q   <= cmd.now;
						ready_q <= cmd.ready;
						cnt_q   <= '0;
						// drop a trigger that arrives mid-sequence
						if (cmd.is_start && !running_q) begin
							running_q <= 1'b1;
							pos_q     <= '0;
							due_q     <= '0;
							state_q   <= ST_EXEC;
						end else if (!cmd.is_start) begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (!is_due) begin
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						kind_q      <= cur.kind;
						key_q       <= cur.key;
						buttons_q   <= cur.buttons;
						delivered_q <= ready_q;
						done_q      <= step_done;
						last_q      <= step_last;
						cnt_q       <= cnt_q + CNT_W'(1);
						if (step_done) begin
							running_q <= 1'b0;
							pos_q     <= '0;
							due_q     <= '0;
						end else begin
							pos_q <= next_pos[POS_W-1:0];
							due_q <= now_q + TIME_W'(cur.delay);
						end
						if (step_last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid  = out_valid_q;
	assign report_kind   = kind_q;
	assign key_code      = key_q;
	assign mouse_buttons = buttons_q;
	assign delivered     = delivered_q;
	assign sequence_done = done_q;
	assign last          = last_q;

endmodule

@@ hw/rtl/timed_hid_macro_sequencer_core.sv @@
`timescale 1ns / 1ps
// Top level of the timed HID macro sequencer: config registers, front and back ends.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  item     | item_valid / item_stall    | action now_ms rpt_id first_byte
//           |                            | report_length host_ready
//  result   | result_valid / result_stall| report_kind key_code mouse_buttons delivered
//           |                            | sequence_done last
//  cfg      | cfg_valid / cfg_ready      | cfg_index cfg_data
//
// Each queued request is loaded in the back end and then runs its due steps one at a
// time (a tick with nothing due goes straight back to idle); the back end's single
// step unit sets this. Reports that are not triggers are dropped at the front and
// never reach the back end. The front takes an item every cycle while its two-entry
// queue has room, so a stalled result only holds up the front once the queue fills.
// Reset clears the sequencer state to idle and the registers to their defaults.
module timed_hid_macro_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        action,
	input  logic [31:0] now_ms,
	input  logic [7:0]  rpt_id,
	input  logic [7:0]  first_byte,
	input  logic [6:0]  report_length,
	input  logic        host_ready,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  report_kind,
	output logic [7:0]  key_code,
	output logic [7:0]  mouse_buttons,
	output logic        delivered,
	output logic        sequence_done,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import thms_pkg::*;

	logic [3:0] step_count_q;
	logic [7:0] trigger_code_q;
	logic [7:0] vendor_id_q;
	logic       cmd_valid;
	cmd_t       cmd;
	logic       cmd_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q   <= STEP_COUNT_RST;
			trigger_code_q <= TRIGGER_CODE_RST;
			vendor_id_q    <= VENDOR_ID_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_STEP_COUNT:   step_count_q   <= cfg_data[3:0];
				CFG_TRIGGER_CODE: trigger_code_q <= cfg_data;
				CFG_VENDOR_ID:    vendor_id_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	thms_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.action           (action),
		.now_ms           (now_ms),
		.rpt_id           (rpt_id),
		.first_byte       (first_byte),
		.report_length    (report_length),
		.host_ready       (host_ready),
		.trigger_code     (trigger_code_q),
		.vendor_id        (vendor_id_q),
		.cmd_valid        (cmd_valid),
		.cmd              (cmd),
		.cmd_pop          (cmd_pop)
	);

	thms_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop),
		.step_count    (step_count_q),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.report_kind   (report_kind),
		.key_code      (key_code),
		.mouse_buttons (mouse_buttons),
		.delivered     (delivered),
		.sequence_done (sequence_done),
		.last          (last)
	);

endmodule

@@ hw/rtl/thms_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the sequencer top level and its bind.
module thms_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic [1:0] report_kind,
	input logic [7:0] key_code,
	input logic [7:0] mouse_buttons,
	input logic       sequence_done,
	input logic       last
);
	import thms_pkg::*;

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(report_kind) &&
		$stable(key_code) && $stable(mouse_buttons) && $stable(sequence_done) &&
		$stable(last))
		else $error("stalled result changed");

	// the step that ends the sequence ends the request's results too
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && sequence_done |-> last)
		else $error("sequence_done without last");

	a_kind_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (report_kind == KIND_KEY || report_kind == KIND_MOUSE))
		else $error("result carries no report kind");

	a_key_or_mouse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (report_kind == KIND_KEY && mouse_buttons == 8'h00) ||
		(report_kind == KIND_MOUSE && key_code == 8'h00))
		else $error("report mixes key and mouse fields");

endmodule

bind timed_hid_macro_sequencer_core thms_checker u_thms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.report_kind   (report_kind),
	.key_code      (key_code),
	.mouse_buttons (mouse_buttons),
	.sequence_done (sequence_done),
	.last          (last)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the timed HID macro sequencer: directed table, random phases, scoreboard.
module testbench;
	import thms_pkg::*;

	localparam int CLK_PERIOD      = 4;
	localparam int RESET_CYCLES    = 9;
	localparam int QUIET_CYCLES    = 16;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int RANDOM_PER_SET  = 48;
	localparam int N_SETTINGS      = 7;
	localparam int N_DIR           = 17;
	localparam int SEQ_LEN         = (TABLE_STEPS < ENTRIES) ? TABLE_STEPS : ENTRIES;

	// index with no register behind it
	localparam logic [1:0] CFG_SPARE = 2'd3;

	// the played step table, entry 0 first
	localparam logic [0:7][1:0] SEQ_KIND = {KIND_MOUSE, KIND_MOUSE, KIND_MOUSE, KIND_MOUSE,
		KIND_KEY, KIND_KEY, KIND_MOUSE, KIND_MOUSE};
	localparam logic [0:7][7:0] SEQ_KEY = {8'h00, 8'h00, 8'h00, 8'h00,
		KEY_EIGHT, 8'h00, 8'h00, 8'h00};
	localparam logic [0:7][7:0] SEQ_BTN = {BTN_R, 8'h00, BTN_L, 8'h00,
		8'h00, 8'h00, BTN_R, 8'h00};
	localparam logic [0:7][6:0] SEQ_DELAY = {7'd10, 7'd90, 7'd10, 7'd5,
		7'd8, 7'd5, 7'd10, 7'd0};

	typedef struct packed {
		logic        act;
		logic [31:0] ms;
		logic [7:0]  rid;
		logic [7:0]  fb;
		logic [6:0]  len;
		logic        rdy;
	} request_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] key;
		logic [7:0] btn;
		logic       dlv;
		logic       done;
		logic       lst;
	} report_t;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_QUIET,
		CHK_TYPED
	} check_t;

	typedef struct packed {
		request_t req;
		check_t   chk;
		report_t  want;
	} dir_row_t;

	localparam report_t NO_REPORT = '0;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        item_valid    = 1'b0;
	logic        item_stall;
	logic        action        = ACT_TICK;
	logic [31:0] now_ms        = '0;
	logic [7:0]  rpt_id        = '0;
	logic [7:0]  first_byte    = '0;
	logic [6:0]  report_length = '0;
	logic        host_ready    = 1'b0;
	logic        result_valid;
	logic        result_stall  = 1'b0;
	logic [1:0]  report_kind;
	logic [7:0]  key_code;
	logic [7:0]  mouse_buttons;
	logic        delivered;
	logic        sequence_done;
	logic        last;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index     = '0;
	logic [7:0]  cfg_data      = '0;

	// sequencer copy used for prediction
	logic [3:0]  cfg_steps;
	logic [7:0]  cfg_trigger;
	logic [7:0]  cfg_vendor;
	logic        seq_running;
	logic [2:0]  seq_pos;
	logic [31:0] seq_due;
	report_t     step_out [MAX_RESULTS];
	int          step_n;

	report_t     pending_reports [$];
	report_t     exp_r;
	dir_row_t    dir_rows [N_DIR];
	logic [31:0] clock_ms;

	int error_count     = 0;
	int requests_sent   = 0;
	int reports_checked = 0;
	int seq_ended       = 0;
	int settings_done   = 0;
	int quiet_cycles    = 0;
	int calm_items      = 0;
	int hold_off_seq    = 0;
	int hold_off_seen   = 0;
	int stall_left      = 0;
	int calm_left       = 0;
	int stall_roll;

	timed_hid_macro_sequencer_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.action        (action),
		.now_ms        (now_ms),
		.rpt_id        (rpt_id),
		.first_byte    (first_byte),
		.report_length (report_length),
		.host_ready    (host_ready),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.report_kind   (report_kind),
		.key_code      (key_code),
		.mouse_buttons (mouse_buttons),
		.delivered     (delivered),
		.sequence_done (sequence_done),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic request_t tick_at(input logic [31:0] ms, input logic rdy);
		request_t r;
		r.act = ACT_TICK;
		r.ms  = ms;
		// report fields are don't-care on a tick, so scramble them
		r.rid = 8'($urandom);
		r.fb  = 8'($urandom);
		r.len = 7'($urandom_range(0, 64));
		r.rdy = rdy;
		return r;
	endfunction

	function automatic request_t report_at(input logic [31:0] ms, input logic [7:0] rid,
		input logic [7:0] fb, input logic [6:0] len, input logic rdy);
		request_t r;
		r.act = ACT_REPORT;
		r.ms  = ms;
		r.rid = rid;
		r.fb  = fb;
		r.len = len;
		r.rdy = rdy;
		return r;
	endfunction

	function automatic report_t step_report(input logic [1:0] kind, input logic [7:0] key,
		input logic [7:0] btn, input logic dlv, input logic done);
		return '{kind: kind, key: key, btn: btn, dlv: dlv, done: done, lst: 1'b1};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_items > 0) begin
			calm_items--;
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 83)
			return $urandom_range(1, 3);
		if (r < 93)
			return $urandom_range(4, 10);
		if (r < 97)
			return $urandom_range(20, 40);
		calm_items = $urandom_range(10, 30);
		return 0;
	endfunction

	// run every due step for one request and leave its reports in step_out
	task automatic predict_request(input request_t req);
		logic [3:0] lim;
		logic [3:0] nxt;
		logic [6:0] dly;
		logic       go;
		step_n = 0;
		go     = 1'b1;
		if (req.act == ACT_REPORT) begin
			if (req.rid == cfg_vendor && req.len != 0 && req.fb == cfg_trigger
				&& !seq_running) begin
				seq_running = 1'b1;
				seq_pos     = '0;
				seq_due     = '0;
			end else begin
				go = 1'b0;
			end
		end
		if (cfg_steps == 4'd0)
			lim = 4'd1;
		else if (cfg_steps > 4'(SEQ_LEN))
			lim = 4'(SEQ_LEN);
		else
			lim = cfg_steps;
		while (go && seq_running && req.ms >= seq_due && step_n < MAX_RESULTS) begin
			nxt = {1'b0, seq_pos} + 4'd1;
			dly = SEQ_DELAY[seq_pos];
			step_out[step_n] = '{kind: SEQ_KIND[seq_pos], key: SEQ_KEY[seq_pos],
				btn: SEQ_BTN[seq_pos], dlv: req.rdy, done: (nxt >= lim), lst: 1'b0};
			step_n++;
			if (nxt >= lim) begin
				seq_running = 1'b0;
				seq_pos     = '0;
				seq_due     = '0;
			end else begin
				seq_pos = nxt[2:0];
				seq_due = req.ms + 32'(dly);
				// zero delay chains into the next step
				go = (dly == 7'd0);
			end
		end
		if (step_n > 0)
			step_out[step_n - 1].lst = 1'b1;
	endtask

	// offer one request, wait for it to be taken, then queue what it should produce
	task automatic issue(input request_t req, input int gap, input check_t chk,
		input report_t want);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action        <= req.act;
		now_ms        <= req.ms;
		rpt_id        <= req.rid;
		first_byte    <= req.fb;
		report_length <= req.len;
		host_ready    <= req.rdy;
		item_valid    <= 1'b1;
		do
			@(posedge clk);
		while (item_stall !== 1'b0);
		predict_request(req);
		case (chk)
			CHK_MODEL: begin
				for (int k = 0; k < step_n; k++)
					pending_reports.push_back(step_out[k]);
			end
			CHK_TYPED: pending_reports.push_back(want);
			default: ;
		endcase
		requests_sent++;
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		case (idx)
			CFG_STEP_COUNT:   cfg_steps   = data[3:0];
			CFG_TRIGGER_CODE: cfg_trigger = data;
			CFG_VENDOR_ID:    cfg_vendor  = data;
			default: ;
		endcase
	endtask

	// trigger, then ticks far enough apart that every step is due
	task automatic run_burst(input int ticks);
		issue(report_at(clock_ms, cfg_vendor, cfg_trigger, 7'($urandom_range(1, 64)),
			1'($urandom)), 0, CHK_MODEL, NO_REPORT);
		for (int k = 0; k < ticks; k++) begin
			clock_ms = clock_ms + 32'd100;
			issue(tick_at(clock_ms, 1'($urandom)), 0, CHK_MODEL, NO_REPORT);
		end
	endtask

	// drain: every report back, then let request-free work finish
	task automatic settle();
		item_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// result side: random stalls, calm stretches, and one long hold-off on request
	always @(posedge clk) begin
		stall_roll = $urandom_range(0, 99);
		if (hold_off_seq != hold_off_seen) begin
			hold_off_seen <= hold_off_seq;
			result_stall  <= 1'b1;
			stall_left    <= HOLD_OFF_CYCLES;
		end else if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left   <= stall_left - 1;
		end else if (calm_left != 0) begin
			result_stall <= 1'b0;
			calm_left    <= calm_left - 1;
		end else if (stall_roll < 70) begin
			result_stall <= 1'b0;
		end else if (stall_roll < 90) begin
			result_stall <= 1'b1;
			stall_left   <= $urandom_range(0, 2);
		end else if (stall_roll < 96) begin
			result_stall <= 1'b1;
			stall_left   <= $urandom_range(10, 40);
		end else begin
			result_stall <= 1'b0;
			calm_left    <= $urandom_range(30, 120);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall == 1'b0) begin
			if (pending_reports.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected report: kind=%0d key=%h btn=%h dlv=%b done=%b last=%b",
						report_kind, key_code, mouse_buttons, delivered, sequence_done, last);
			end else begin
				exp_r = pending_reports.pop_front();
				if (exp_r.kind !== report_kind || exp_r.key !== key_code
					|| exp_r.btn !== mouse_buttons || exp_r.dlv !== delivered
					|| exp_r.done !== sequence_done || exp_r.lst !== last) begin
					error_count++;
					if (error_count <= 10) begin
						$display("report %0d expected: kind=%0d key=%h btn=%h dlv=%b done=%b last=%b",
							reports_checked, exp_r.kind, exp_r.key, exp_r.btn, exp_r.dlv,
							exp_r.done, exp_r.lst);
						$display("report %0d actual:   kind=%0d key=%h btn=%h dlv=%b done=%b last=%b",
							reports_checked, report_kind, key_code, mouse_buttons, delivered,
							sequence_done, last);
					end
				end
			end
			if (sequence_done === 1'b1)
				seq_ended++;
			reports_checked++;
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall)
			|| (cfg_valid && cfg_ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d reports outstanding",
				quiet_cycles, pending_reports.size());
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		request_t    req;
		logic [7:0]  set_steps;
		logic [7:0]  set_trig;
		logic [7:0]  set_vend;
		int          roll;
		int          sel;

		cfg_steps   = STEP_COUNT_RST;
		cfg_trigger = TRIGGER_CODE_RST;
		cfg_vendor  = VENDOR_ID_RST;
		seq_running = 1'b0;
		seq_pos     = '0;
		seq_due     = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: step count 8, trigger 0x51, vendor id 3
		dir_rows[0]  = '{tick_at(32'd0, 1'b1), CHK_QUIET, NO_REPORT};
		dir_rows[1]  = '{report_at(32'd5, VENDOR_ID_RST, TRIGGER_CODE_RST, 7'd0, 1'b1),
			CHK_QUIET, NO_REPORT};
		dir_rows[2]  = '{report_at(32'd5, VENDOR_ID_RST, 8'h50, 7'd1, 1'b1),
			CHK_QUIET, NO_REPORT};
		dir_rows[3]  = '{report_at(32'd5, 8'd2, TRIGGER_CODE_RST, 7'd64, 1'b1),
			CHK_QUIET, NO_REPORT};
		dir_rows[4]  = '{report_at(32'd100, VENDOR_ID_RST, TRIGGER_CODE_RST, 7'd64, 1'b1),
			CHK_TYPED, step_report(KIND_MOUSE, 8'h00, BTN_R, 1'b1, 1'b0)};
		// trigger while running must not advance anything
		dir_rows[5]  = '{report_at(32'd200, VENDOR_ID_RST, TRIGGER_CODE_RST, 7'd1, 1'b1),
			CHK_QUIET, NO_REPORT};
		dir_rows[6]  = '{tick_at(32'd109, 1'b1), CHK_QUIET, NO_REPORT};
		dir_rows[7]  = '{tick_at(32'd110, 1'b0), CHK_TYPED,
			step_report(KIND_MOUSE, 8'h00, 8'h00, 1'b0, 1'b0)};
		// deadline wraps past zero to 9
		dir_rows[8]  = '{tick_at(32'hFFFF_FFFF, 1'b1), CHK_TYPED,
			step_report(KIND_MOUSE, 8'h00, BTN_L, 1'b1, 1'b0)};
		dir_rows[9]  = '{tick_at(32'd8, 1'b1), CHK_QUIET, NO_REPORT};
		dir_rows[10] = '{tick_at(32'd9, 1'b0), CHK_MODEL, NO_REPORT};
		dir_rows[11] = '{tick_at(32'd14, 1'b1), CHK_TYPED,
			step_report(KIND_KEY, KEY_EIGHT, 8'h00, 1'b1, 1'b0)};
		dir_rows[12] = '{tick_at(32'd30, 1'b1), CHK_MODEL, NO_REPORT};
		dir_rows[13] = '{tick_at(32'd35, 1'b0), CHK_MODEL, NO_REPORT};
		// final zero-delay step ends the sequence
		dir_rows[14] = '{tick_at(32'h8000_0000, 1'b1), CHK_TYPED,
			step_report(KIND_MOUSE, 8'h00, 8'h00, 1'b1, 1'b1)};
		dir_rows[15] = '{tick_at(32'hFFFF_FFFF, 1'b1), CHK_QUIET, NO_REPORT};
		dir_rows[16] = '{report_at(32'd0, 8'hFF, 8'hFF, 7'd64, 1'b0), CHK_QUIET, NO_REPORT};

		for (int i = 0; i < N_DIR; i++)
			issue(dir_rows[i].req, pick_gap(), dir_rows[i].chk, dir_rows[i].want);

		clock_ms = 32'($urandom_range(0, 1000));
		for (int ph = 0; ph < N_SETTINGS; ph++) begin
			settle();
			case (ph)
				0: begin
					set_steps = 8'h00;
					set_trig  = 8'h00;
					set_vend  = 8'hFF;
				end
				1: begin
					set_steps = 8'h0F;
					set_trig  = 8'hFF;
					set_vend  = 8'h00;
				end
				2: begin
					// upper nibble is outside the count field
					set_steps = 8'hF3;
					set_trig  = 8'($urandom);
					set_vend  = 8'($urandom);
				end
				3: begin
					set_steps = 8'h01;
					set_trig  = 8'($urandom);
					set_vend  = 8'($urandom);
				end
				4: begin
					set_steps = {4'h0, STEP_COUNT_RST};
					set_trig  = TRIGGER_CODE_RST;
					set_vend  = VENDOR_ID_RST;
				end
				5: begin
					// lowered while the previous sequence is still running
					set_steps = 8'h02;
					set_trig  = 8'($urandom);
					set_vend  = 8'($urandom);
				end
				default: begin
					set_steps = 8'($urandom_range(0, 15));
					set_trig  = 8'($urandom);
					set_vend  = 8'($urandom);
				end
			endcase
			write_reg(CFG_STEP_COUNT, set_steps);
			write_reg(CFG_TRIGGER_CODE, set_trig);
			write_reg(CFG_VENDOR_ID, set_vend);
			if (ph == 2)
				write_reg(CFG_SPARE, 8'($urandom));
			cfg_valid <= 1'b0;
			settings_done++;

			if (ph == 4) begin
				// hold results off while a full sequence is offered back to back
				hold_off_seq <= hold_off_seq + 1;
				run_burst(SEQ_LEN - 1);
			end

			for (int n = 0; n < RANDOM_PER_SET; n++) begin
				roll = $urandom_range(0, 99);
				if ((!seq_running && roll < 45) || roll < 8) begin
					req = report_at(clock_ms, cfg_vendor, cfg_trigger,
						7'($urandom_range(1, 64)), 1'($urandom));
				end else if (roll < 82) begin
					sel = $urandom_range(0, 99);
					if (sel < 55)
						clock_ms = clock_ms + 32'($urandom_range(0, 12));
					else if (sel < 90)
						clock_ms = clock_ms + 32'($urandom_range(13, 100));
					else if (sel < 95)
						clock_ms = $urandom();
					else
						clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 60));
					req = tick_at(clock_ms, 1'($urandom));
				end else begin
					// near misses and noise
					sel = $urandom_range(0, 3);
					req = report_at(clock_ms, cfg_vendor, cfg_trigger,
						7'($urandom_range(1, 64)), 1'($urandom));
					case (sel)
						0: req.len = 7'd0;
						1: req.rid = cfg_vendor ^ 8'($urandom_range(1, 255));
						2: req.fb  = cfg_trigger ^ 8'($urandom_range(1, 255));
						default: begin
							req.rid = 8'($urandom);
							req.fb  = 8'($urandom);
							req.len = 7'($urandom_range(0, 64));
						end
					endcase
				end
				issue(req, pick_gap(), CHK_MODEL, NO_REPORT);
			end
			// leave a sequence in flight for the next setting
			run_burst(2);
		end
		settle();

		if (pending_reports.size() != 0) begin
			$display("%0d expected reports never arrived", pending_reports.size());
			error_count++;
		end
		$display("covered %0d requests under %0d register settings plus reset values",
			requests_sent, settings_done);
		$display("checked %0d step reports, %0d of them ending a sequence",
			reports_checked, seq_ended);
		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ timed_hid_macro_sequencer_core.f @@
hw/rtl/thms_pkg.sv
hw/rtl/thms_front.sv
hw/rtl/thms_back.sv
hw/rtl/timed_hid_macro_sequencer_core.sv
hw/rtl/thms_checker.sv
tb/testbench.sv
